[src/gae_pkg.sv]
// Package for the advantage estimator: beat structs, register indexes, widths.
// No dependencies; gae_alu and the top level refer to it by scoped names.
package gae_pkg;

  localparam int DEFAULT_MAX_STEPS = 64;
  localparam int DATA_W            = 32;
  localparam int FACTOR_W          = 17;
  localparam int CFG_IDX_W         = 1;

  localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY    = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] td_value;
    logic                     seq_end;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] advantage;
    logic                     last_out;
    logic                     overflowed;
  } out_item_t;

  function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] f);
    logic over;
    over = f[FACTOR_W-1] && (|f[FACTOR_W-2:0]);
    return over ? FACTOR_ONE : f;
  endfunction

endpackage

[src/gae_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/gae_alu.sv]
// Shared arithmetic unit: registered 17x32 multiply, >>>16, saturating add.
// Depends on gae_pkg for data and factor widths.
module gae_alu (
  input  logic                                clk,
  input  logic [gae_pkg::FACTOR_W-1:0]        mul_a,
  input  logic signed [gae_pkg::DATA_W-1:0]   mul_b,
  input  logic signed [gae_pkg::DATA_W-1:0]   add_in,
  output logic signed [gae_pkg::DATA_W+1:0]   prod_shift,
  output logic signed [gae_pkg::DATA_W-1:0]   sum_sat
);

  localparam int PW = gae_pkg::FACTOR_W + 1 + gae_pkg::DATA_W;
  localparam int SW = gae_pkg::DATA_W + 3;

  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] sum;

  always_ff @(posedge clk) begin
    prod <= PW'($signed({1'b0, mul_a})) * PW'(mul_b);
  end

  // floor(prod / 2^16)
  assign prod_shift = prod[PW-1:16];

  assign sum = {{3{add_in[gae_pkg::DATA_W-1]}}, add_in}
             + {prod_shift[gae_pkg::DATA_W+1], prod_shift};

  always_comb begin
    if (sum[SW-1:gae_pkg::DATA_W-1] == '0 || sum[SW-1:gae_pkg::DATA_W-1] == '1) begin
      sum_sat = sum[gae_pkg::DATA_W-1:0];
    end else if (sum[SW-1]) begin
      sum_sat = {1'b1, {(gae_pkg::DATA_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(gae_pkg::DATA_W-1){1'b1}}};
    end
  end

endmodule

[src/generalized_advantage_estimate.sv]
// Advantage estimator top level: sequencer, config registers, delta store.
// Depends on gae_pkg, gae_ram and gae_alu.
//
//   channel   handshake        payload            notes
//   input     start / busy     item (in_item_t)   taken when start && !busy
//   result    done             result (out_item_t) one cycle per beat, no stall
//   config    cfg_we           cfg_addr, cfg_data  write only, takes effect next cycle
//
// A closing item with n buffered steps holds busy through the factor product
// (KMUL, KSET), the reverse pass through the one multiplier and adder (RMUL,
// RADD per step) and the forward emit from the store (EMIT per step, DRAIN).
// Result beats follow one per cycle. The receiver cannot stall results.
// Synchronous reset clears the count, overflow flag, sequencer and done, and
// sets both factors to one; the store needs no clearing.
module generalized_advantage_estimate #(
  parameter int MAX_STEPS = gae_pkg::DEFAULT_MAX_STEPS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  gae_pkg::in_item_t               item,
  input  logic                            cfg_we,
  input  logic [gae_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [gae_pkg::FACTOR_W-1:0]    cfg_data,
  output logic                            done,
  output gae_pkg::out_item_t              result
);

  localparam int AW = $clog2(MAX_STEPS);
  localparam int CW = $clog2(MAX_STEPS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_STEPS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_KMUL  = 3'd1;
  localparam logic [2:0] S_KSET  = 3'd2;
  localparam logic [2:0] S_RMUL  = 3'd3;
  localparam logic [2:0] S_RADD  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;

  logic [2:0]                     state;
  logic [CW-1:0]                  cnt;
  logic                           ovf;
  logic [CW-1:0]                  ptr;
  logic [AW-1:0]                  eptr;
  logic                           pend;
  logic                           pend_last;
  logic [gae_pkg::FACTOR_W-1:0]   discount;
  logic [gae_pkg::FACTOR_W-1:0]   decay;
  logic [gae_pkg::FACTOR_W-1:0]   k;
  logic signed [gae_pkg::DATA_W-1:0] acc;

  logic                           accept;
  logic                           room;
  logic [CW-1:0]                  cnt_next;
  logic [CW-1:0]                  ptr_dec;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [gae_pkg::DATA_W-1:0]     ram_wdata;
  logic [AW-1:0]                  ram_raddr;
  logic [gae_pkg::DATA_W-1:0]     ram_rdata;
  logic [gae_pkg::FACTOR_W-1:0]   mul_a;
  logic signed [gae_pkg::DATA_W-1:0] mul_b;
  logic signed [gae_pkg::DATA_W+1:0] prod_shift;
  logic signed [gae_pkg::DATA_W-1:0] sum_sat;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign room     = (cnt != CAP);
  assign cnt_next = room ? cnt + CW'(1) : cnt;
  assign ptr_dec  = ptr - CW'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt[AW-1:0];
    ram_wdata = item.td_value;
    ram_raddr = eptr;
    mul_a     = k;
    mul_b     = acc;
    case (state)
      S_IDLE: begin
        ram_we = accept && room;
      end
      S_KMUL: begin
        mul_a = gae_pkg::clamp_factor(decay);
        mul_b = $signed({{(gae_pkg::DATA_W-gae_pkg::FACTOR_W){1'b0}},
                         gae_pkg::clamp_factor(discount)});
      end
      S_RMUL: begin
        ram_raddr = ptr_dec[AW-1:0];
      end
      S_RADD: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_dec[AW-1:0];
        ram_wdata = sum_sat;
      end
      default: begin
      end
    endcase
  end

  gae_ram #(
    .WIDTH (gae_pkg::DATA_W),
    .DEPTH (MAX_STEPS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gae_alu u_alu (
    .clk        (clk),
    .mul_a      (mul_a),
    .mul_b      (mul_b),
    .add_in     ($signed(ram_rdata)),
    .prod_shift (prod_shift),
    .sum_sat    (sum_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      discount <= gae_pkg::FACTOR_ONE;
      decay    <= gae_pkg::FACTOR_ONE;
    end else if (cfg_we) begin
      case (cfg_addr)
        gae_pkg::REG_DISCOUNT: discount <= cfg_data;
        gae_pkg::REG_DECAY:    decay    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      ovf   <= 1'b0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= pend;
      pend <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cnt <= cnt_next;
            if (!room) begin
              ovf <= 1'b1;
            end
            if (item.seq_end) begin
              ptr   <= cnt_next;
              state <= S_KMUL;
            end
          end
        end
        S_KMUL: begin
          state <= S_KSET;
        end
        S_KSET: begin
          k     <= prod_shift[gae_pkg::FACTOR_W-1:0];
          acc   <= '0;
          state <= S_RMUL;
        end
        S_RMUL: begin
          state <= S_RADD;
        end
        S_RADD: begin
          acc <= sum_sat;
          ptr <= ptr_dec;
          if (ptr == CW'(1)) begin
            eptr  <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_RMUL;
          end
        end
        S_EMIT: begin
          pend      <= 1'b1;
          pend_last <= ({1'b0, eptr} == cnt - CW'(1));
          eptr      <= eptr + AW'(1);
          if ({1'b0, eptr} == cnt - CW'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          cnt   <= '0;
          ovf   <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      result.advantage  <= $signed(ram_rdata);
      result.last_out   <= pend_last;
      result.overflowed <= ovf;
    end
  end

endmodule
